[src/smm_pkg.sv]
// Shared constants and types for the square matrix multiplier.
package smm_pkg;

  // Matrix size and derived counts.
  localparam int MATRIX_DIM  = 8;
  localparam int ELEM_COUNT  = MATRIX_DIM * MATRIX_DIM;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LOAD_W      = 7;
  localparam int IDX_W       = 3;
  localparam int DATA_W      = 32;

  // Last value of a row, column or inner-sum counter.
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MATRIX_DIM - 1);

  // Tag that travels with each read through the multiply-accumulate pipeline.
  typedef struct packed {
    logic             first_k;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_elem;
  } mac_tag_t;

endpackage

[src/square_matrix_multiply_core.sv]
// Top level of the square matrix multiplier: load sequencer, element stores and MAC.
//
// The block takes MATRIX_DIM*MATRIX_DIM pairs (a_value, b_value), one element of A and
// one of B per transfer in row-major order, at one transfer per cycle. After the pair
// that completes both matrices it stops taking input and steps one shared
// multiply-accumulate unit through the product, reading one element of A and one of B
// from their RAMs each cycle while the pipeline is not frozen. Results come out in
// row-major order with their row and column, the final one flagged by last_element;
// sums wrap modulo 2^32. Output backpressure freezes the pipeline when a finished sum
// has nowhere to go. Loading of the next pair of matrices resumes as soon as the last
// read is issued, while the final results still drain.
module square_matrix_multiply_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [smm_pkg::DATA_W-1:0] a_value,
  input  logic signed [smm_pkg::DATA_W-1:0] b_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [smm_pkg::DATA_W-1:0] c_value,
  output logic [smm_pkg::IDX_W-1:0]    row_index,
  output logic [smm_pkg::IDX_W-1:0]    col_index,
  output logic                         last_element
);

  import smm_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_COMPUTE
  } state_t;

  localparam logic [LOAD_W-1:0] LOAD_LAST = LOAD_W'(ELEM_COUNT - 1);
  localparam logic [ADDR_W-1:0] DIM_ADDR  = ADDR_W'(MATRIX_DIM);

  state_t            state;
  logic [LOAD_W-1:0] load_count;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  k;
  logic              load_xfer;
  logic              advance;
  logic              issue;
  mac_tag_t          issue_tag;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;

  assign in_ready  = (state == ST_LOAD);
  assign load_xfer = in_valid && in_ready;
  assign issue     = (state == ST_COMPUTE) && advance;

  // Read addresses: A[row][k] and B[k][col].
  assign a_raddr = ADDR_W'(ADDR_W'(row) * DIM_ADDR + ADDR_W'(k));
  assign b_raddr = ADDR_W'(ADDR_W'(k) * DIM_ADDR + ADDR_W'(col));

  // Tag for the term being read this cycle.
  always_comb begin
    issue_tag.first_k   = (k == '0);
    issue_tag.last_k    = (k == IDX_LAST);
    issue_tag.row       = row;
    issue_tag.col       = col;
    issue_tag.last_elem = (row == IDX_LAST) && (col == IDX_LAST);
  end

  // Load counter and the sweep over row, column and inner index.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (load_xfer) begin
            if (load_count == LOAD_LAST) begin
              load_count <= '0;
              row        <= '0;
              col        <= '0;
              k          <= '0;
              state      <= ST_COMPUTE;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        ST_COMPUTE: begin
          if (issue) begin
            if (k == IDX_LAST) begin
              k <= '0;
              if (col == IDX_LAST) begin
                col <= '0;
                if (row == IDX_LAST) begin
                  row   <= '0;
                  state <= ST_LOAD;
                end else begin
                  row <= row + 1'b1;
                end
              end else begin
                col <= col + 1'b1;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Element stores for A and B.
  smm_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (STORE_DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (load_xfer),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (a_value),
    .re    (issue),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  smm_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (STORE_DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (load_xfer),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (b_value),
    .re    (issue),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  // Shared multiply-accumulate unit and output register.
  smm_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .issue        (issue),
    .issue_tag    (issue_tag),
    .a_q          (a_q),
    .b_q          (b_q),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .c_value      (c_value),
    .row_index    (row_index),
    .col_index    (col_index),
    .last_element (last_element)
  );

  // The final element of the product sits in the last row and column.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_element |-> (row_index == IDX_LAST) && (col_index == IDX_LAST))
    else $error("last_element flagged away from the final row and column");

  // A stalled result is never overwritten by the accumulator.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(c_value) && $stable(row_index))
    else $error("stalled result changed before its transfer");

  // The transfer that completes the load starts the sweep at the first term.
  a_start: assert property (@(posedge clk) disable iff (rst)
    load_xfer && (load_count == LOAD_LAST) |=>
      (state == ST_COMPUTE) && (row == '0) && (col == '0) && (k == '0))
    else $error("product sweep did not start after a complete load");

endmodule

[src/smm_ram.sv]
// Simple dual-port synchronous RAM with a registered read port.
module smm_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/smm_mac.sv]
// Multiply-accumulate pipeline and output register of the matrix multiplier.
module smm_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         issue,
  input  smm_pkg::mac_tag_t            issue_tag,
  input  logic [smm_pkg::DATA_W-1:0]   a_q,
  input  logic [smm_pkg::DATA_W-1:0]   b_q,
  output logic                         advance,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [smm_pkg::DATA_W-1:0] c_value,
  output logic [smm_pkg::IDX_W-1:0]    row_index,
  output logic [smm_pkg::IDX_W-1:0]    col_index,
  output logic                         last_element
);

  import smm_pkg::*;

  logic              d_v;
  mac_tag_t          d_tag;
  logic              p_v;
  mac_tag_t          p_tag;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] sum;

  // The pipeline freezes only when a finished sum has nowhere to go.
  assign advance = !(out_valid && !out_ready && p_v && p_tag.last_k);

  // Running sum, restarted on the first term of each element; wraps mod 2^32.
  assign sum = (p_tag.first_k ? '0 : acc) + prod;

  // Pipeline valid bits and the output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v       <= 1'b0;
      p_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        d_v <= issue;
        p_v <= d_v;
      end
      // A result stays until its transfer; a finished sum refills the register.
      out_valid <= (out_valid && !out_ready) || (advance && p_v && p_tag.last_k);
    end
  end

  // Payload: tags, low half of the product, accumulator and result.
  always_ff @(posedge clk) begin
    if (advance) begin
      d_tag <= issue_tag;
      p_tag <= d_tag;
      prod  <= a_q * b_q;
      if (p_v) begin
        acc <= sum;
      end
      if (p_v && p_tag.last_k) begin
        c_value      <= sum;
        row_index    <= p_tag.row;
        col_index    <= p_tag.col;
        last_element <= p_tag.last_elem;
      end
    end
  end

endmodule
